// ===== rtl/p2c_pkg.sv =====
// Shared types, constants and the lane operation table for the PK2 to Cauchy
// stress push-forward. Depends on nothing; every other file imports it.
`default_nettype none

package p2c_pkg;

    localparam int DIM      = 3;
    localparam int CELLS    = DIM * DIM;
    localparam int CELL_W   = $clog2(CELLS);
    localparam int ELEM_W   = 48;
    localparam int FRAC_W   = 24;
    localparam int DIG_W    = 24;
    // intermediate S*F^T and cofactor values, sign included
    localparam int TMP_W    = 97;
    localparam int MAG_A_W  = TMP_W - 1;
    // sums of three triple products
    localparam int ACC_W    = 146;
    localparam int N_OPS    = 21;
    localparam int STEP_W   = $clog2(N_OPS);

    // first step of each phase of the lane program
    localparam int OP_COF_A = 0;
    localparam int OP_COF_B = 1;
    localparam int OP_DET   = 2;
    localparam int OP_TMP0  = 3;
    localparam int OP_SIG0  = OP_TMP0 + CELLS;

    localparam logic [1:0] ROW_LAST = 2'd2;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef t_elem [CELLS-1:0]         t_mat;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef t_acc [DIM-1:0]            t_acc_row;

    localparam t_elem SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam t_elem SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    typedef enum logic [1:0] {A_GRAD, A_COF, A_TMP} t_a_src;
    typedef enum logic {B_GRAD, B_STRESS} t_b_src;
    typedef enum logic [2:0] {DST_NONE, DST_COF, DST_DET, DST_TMP, DST_SIG} t_dst;

    typedef struct packed {
        t_a_src     a_src;
        logic [1:0] a_row;
        logic [1:0] a_col;
        t_b_src     b_src;
        logic [1:0] b_row;
        logic [1:0] b_col;
        logic       first;
        logic       sub;
        t_dst       dst;
        logic [1:0] d_idx;
    } t_op;

    function automatic logic [CELL_W-1:0] cell_idx(input logic [1:0] row,
                                                   input logic [1:0] col);
        return CELL_W'({2'b00, row} * 4'd3 + {2'b00, col});
    endfunction

    // {k / 3, k % 3} for k in 0..8
    function automatic logic [3:0] split3(input logic [3:0] k);
        logic [3:0] r;
        case (k)
            4'd0:    r = {2'd0, 2'd0};
            4'd1:    r = {2'd0, 2'd1};
            4'd2:    r = {2'd0, 2'd2};
            4'd3:    r = {2'd1, 2'd0};
            4'd4:    r = {2'd1, 2'd1};
            4'd5:    r = {2'd1, 2'd2};
            4'd6:    r = {2'd2, 2'd0};
            4'd7:    r = {2'd2, 2'd1};
            4'd8:    r = {2'd2, 2'd2};
            default: r = {2'd0, 2'd0};
        endcase
        return r;
    endfunction

    // Lane j program: cofactor C0j, F0j*C0j, T(a,j) = sum_b S(a,b)F(j,b),
    // then sigma(i,j) = sum_a F(i,a)T(a,j).
    function automatic t_op op_of(input logic [1:0] lane,
                                  input logic [STEP_W-1:0] step);
        t_op        op;
        logic [1:0] j1;
        logic [1:0] j2;
        logic [3:0] hl;
        j1 = (lane == 2'd2) ? 2'd0 : lane + 2'd1;
        j2 = (j1 == 2'd2) ? 2'd0 : j1 + 2'd1;
        op.a_src = A_GRAD;
        op.a_row = 2'd0;
        op.a_col = 2'd0;
        op.b_src = B_GRAD;
        op.b_row = 2'd0;
        op.b_col = 2'd0;
        op.first = 1'b0;
        op.sub   = 1'b0;
        op.dst   = DST_NONE;
        op.d_idx = 2'd0;
        hl       = 4'd0;
        if (step == STEP_W'(OP_COF_A)) begin
            op.a_row = 2'd1;
            op.a_col = j1;
            op.b_row = 2'd2;
            op.b_col = j2;
            op.first = 1'b1;
        end else if (step == STEP_W'(OP_COF_B)) begin
            op.a_row = 2'd1;
            op.a_col = j2;
            op.b_row = 2'd2;
            op.b_col = j1;
            op.sub   = 1'b1;
            op.dst   = DST_COF;
        end else if (step == STEP_W'(OP_DET)) begin
            op.a_src = A_COF;
            op.b_row = 2'd0;
            op.b_col = lane;
            op.first = 1'b1;
            op.dst   = DST_DET;
        end else if (step < STEP_W'(OP_SIG0)) begin
            hl       = split3(4'(step - STEP_W'(OP_TMP0)));
            op.a_row = lane;
            op.a_col = hl[1:0];
            op.b_src = B_STRESS;
            op.b_row = hl[3:2];
            op.b_col = hl[1:0];
            op.first = (hl[1:0] == 2'd0);
            op.dst   = (hl[1:0] == 2'd2) ? DST_TMP : DST_NONE;
            op.d_idx = hl[3:2];
        end else begin
            hl       = split3(4'(step - STEP_W'(OP_SIG0)));
            op.a_src = A_TMP;
            op.a_col = hl[1:0];
            op.b_row = hl[3:2];
            op.b_col = hl[1:0];
            op.first = (hl[1:0] == 2'd0);
            op.dst   = (hl[1:0] == 2'd2) ? DST_SIG : DST_NONE;
            op.d_idx = hl[3:2];
        end
        return op;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/p2c_if.sv =====
// Valid/ready channel interfaces for the input rows and the result rows.
// Depends on p2c_pkg.
`default_nettype none

interface p2c_in_if;
    import p2c_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] row_index;
    t_elem      grad_a;
    t_elem      grad_b;
    t_elem      grad_c;
    t_elem      stress_a;
    t_elem      stress_b;
    t_elem      stress_c;

    modport source(output valid, row_index, grad_a, grad_b, grad_c,
                   stress_a, stress_b, stress_c, input ready);
    modport sink(input valid, row_index, grad_a, grad_b, grad_c,
                 stress_a, stress_b, stress_c, output ready);
endinterface

interface p2c_out_if;
    import p2c_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] out_row;
    t_elem      cauchy_a;
    t_elem      cauchy_b;
    t_elem      cauchy_c;
    logic       singular;
    logic       last_row;

    modport source(output valid, out_row, cauchy_a, cauchy_b, cauchy_c,
                   singular, last_row, input ready);
    modport sink(input valid, out_row, cauchy_a, cauchy_b, cauchy_c,
                 singular, last_row, output ready);
endinterface

`default_nettype wire

// ===== rtl/pk2_to_cauchy_stress_push_forward.sv =====
// PK2 to Cauchy stress push-forward: sigma = F S F^T / det(F), 3x3, Q24.24.
// Top level: row stores, three column lanes, det merge, dividers, output
// register. Depends on p2c_pkg, p2c_if, p2c_lane, p2c_div.
//
// Channels: i_in takes one row of F and S per item (row_index 0..2, index 3
// is taken and dropped). o_out gives three result rows per set, last_row on
// row 2, singular with zero values when det(F) is zero.
// Rows 0 and 1 are only stored. Row 2 starts the set: the three lanes
// run 21 multiply-accumulate steps, the ST_DET state merges det(F),
// then each result row goes through the 48-bit one-bit-a-cycle division
// in the three column dividers. A singular set skips the division.
// i_in.ready is high only while no set is at work. The result register
// holds a row until o_out.ready; a stall there halts the row sequence, and
// once the last row sits in the register new items are taken again.
// Synchronous reset clears the control state and drops any pending result;
// row stores are undefined until written.
`default_nettype none

module pk2_to_cauchy_stress_push_forward (
    input  logic         i_clk,
    input  logic         i_rst_n,
    p2c_in_if.sink       i_in,
    p2c_out_if.source    o_out
);
    import p2c_pkg::*;

    typedef enum logic [2:0] {ST_IDLE, ST_MAC, ST_DET, ST_DIV, ST_WAIT, ST_PUT} t_state;

    t_state          r_state;
    t_mat            r_grad;
    t_mat            r_stress;
    t_acc            r_det;
    logic [1:0]      r_row;
    logic            r_sing;
    logic            r_out_vld;
    logic [1:0]      r_out_row;
    t_elem           r_out_a;
    t_elem           r_out_b;
    t_elem           r_out_c;
    logic            r_out_sing;
    logic            r_out_last;

    logic            in_acc;
    logic            lane_start;
    logic [DIM-1:0]  lane_busy;
    logic [DIM-1:0]  div_busy;
    t_acc            det_part [DIM];
    t_acc_row        lane_sig [DIM];
    t_elem           quo [DIM];
    t_acc            det_sum;
    logic            sing;
    logic            div_start;
    logic            out_free;

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign lane_start = in_acc && (i_in.row_index == ROW_LAST);
    assign det_sum    = det_part[0] + det_part[1] + det_part[2];
    assign sing       = (r_det == '0);
    assign div_start  = (r_state == ST_DIV) && !sing;
    assign out_free   = !r_out_vld || o_out.ready;

    for (genvar g = 0; g < DIM; g++) begin : g_lane
        p2c_lane #(.LANE(2'(g))) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (lane_start),
            .i_grad     (r_grad),
            .i_stress   (r_stress),
            .o_busy     (lane_busy[g]),
            .o_det_part (det_part[g]),
            .o_sig      (lane_sig[g])
        );

        p2c_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (div_start),
            .i_num   (lane_sig[g][r_row]),
            .i_den   (r_det),
            .o_busy  (div_busy[g]),
            .o_quo   (quo[g])
        );
    end

    // row stores
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.row_index <= ROW_LAST) begin
            r_grad[cell_idx(i_in.row_index, 2'd0)]   <= i_in.grad_a;
            r_grad[cell_idx(i_in.row_index, 2'd1)]   <= i_in.grad_b;
            r_grad[cell_idx(i_in.row_index, 2'd2)]   <= i_in.grad_c;
            r_stress[cell_idx(i_in.row_index, 2'd0)] <= i_in.stress_a;
            r_stress[cell_idx(i_in.row_index, 2'd1)] <= i_in.stress_b;
            r_stress[cell_idx(i_in.row_index, 2'd2)] <= i_in.stress_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
            r_row     <= 2'd0;
        end else begin
            // a row loaded this cycle takes precedence over the drain
            if (o_out.ready && !(r_state == ST_PUT && out_free)) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (lane_start) begin
                        r_state <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    if (lane_busy == '0) begin
                        r_state <= ST_DET;
                    end
                end
                ST_DET: begin
                    r_det   <= det_sum;
                    r_row   <= 2'd0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_sing  <= sing;
                    r_state <= sing ? ST_PUT : ST_WAIT;
                end
                ST_WAIT: begin
                    if (div_busy == '0) begin
                        r_state <= ST_PUT;
                    end
                end
                ST_PUT: begin
                    if (out_free) begin
                        r_out_vld  <= 1'b1;
                        r_out_row  <= r_row;
                        r_out_a    <= r_sing ? '0 : quo[0];
                        r_out_b    <= r_sing ? '0 : quo[1];
                        r_out_c    <= r_sing ? '0 : quo[2];
                        r_out_sing <= r_sing;
                        r_out_last <= (r_row == ROW_LAST);
                        if (r_row == ROW_LAST) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_row   <= r_row + 2'd1;
                            r_state <= ST_DIV;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid    = r_out_vld;
    assign o_out.out_row  = r_out_row;
    assign o_out.cauchy_a = r_out_a;
    assign o_out.cauchy_b = r_out_b;
    assign o_out.cauchy_c = r_out_c;
    assign o_out.singular = r_out_sing;
    assign o_out.last_row = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/p2c_lane.sv =====
// One column lane: runs the fixed multiply-accumulate program on its own
// 24x24 digit multiplier. Depends on p2c_pkg.
`default_nettype none

module p2c_lane #(
    parameter logic [1:0] LANE = 2'd0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  p2c_pkg::t_mat     i_grad,
    input  p2c_pkg::t_mat     i_stress,
    output logic              o_busy,
    output p2c_pkg::t_acc     o_det_part,
    output p2c_pkg::t_acc_row o_sig
);
    import p2c_pkg::*;

    localparam int N_DIG     = (MAG_A_W / DIG_W) * (ELEM_W / DIG_W);
    localparam int PP_FIRST  = 1;
    localparam int PP_LAST   = N_DIG;
    localparam int ACC_FIRST = 2;
    localparam int ACC_LAST  = N_DIG + 1;
    localparam int CNT_LAST  = N_DIG + 2;
    localparam int CNT_W     = $clog2(CNT_LAST + 1);

    logic                     r_busy;
    logic [STEP_W-1:0]        r_step;
    logic [CNT_W-1:0]         r_cnt;
    logic [MAG_A_W-1:0]       r_mag_a;
    logic [ELEM_W-1:0]        r_mag_b;
    logic                     r_neg;
    logic [ELEM_W-1:0]        r_pp;
    logic [2:0]               r_pp_sh;
    t_acc                     r_acc;
    logic signed [TMP_W-1:0]  r_cof;
    logic signed [TMP_W-1:0]  r_tmp [DIM];
    t_acc                     r_det;
    t_acc_row                 r_sig;

    t_op                      op;
    t_elem                    a_elem;
    t_elem                    b_elem;
    logic signed [TMP_W-1:0]  a_val;
    logic signed [TMP_W-1:0]  a_abs;
    logic signed [ELEM_W:0]   b_wide;
    logic signed [ELEM_W:0]   b_abs;
    logic [2:0]               dig;
    logic [ACC_W-1:0]         pp_sh;

    always_comb begin
        op     = op_of(LANE, r_step);
        a_elem = i_grad[cell_idx(op.a_row, op.a_col)];
        case (op.a_src)
            A_GRAD:  a_val = TMP_W'(a_elem);
            A_COF:   a_val = r_cof;
            A_TMP:   a_val = r_tmp[op.a_col];
            default: a_val = r_cof;
        endcase
        b_elem = (op.b_src == B_STRESS) ? i_stress[cell_idx(op.b_row, op.b_col)]
                                        : i_grad[cell_idx(op.b_row, op.b_col)];
        a_abs  = a_val[TMP_W-1] ? -a_val : a_val;
        b_wide = (ELEM_W+1)'(b_elem);
        b_abs  = b_wide[ELEM_W] ? -b_wide : b_wide;
        dig    = 3'(r_cnt - CNT_W'(PP_FIRST));
        pp_sh  = ACC_W'(r_pp) << (DIG_W * r_pp_sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_cnt  <= '0;
        end else if (!r_busy) begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_cnt  <= '0;
            end
        end else begin
            if (r_cnt == CNT_W'(CNT_LAST)) begin
                r_cnt  <= '0;
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(N_OPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // operand latch, digit products, signed accumulate, then write-back
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            if (r_cnt == '0) begin
                r_mag_a <= a_abs[MAG_A_W-1:0];
                r_mag_b <= b_abs[ELEM_W-1:0];
                r_neg   <= a_val[TMP_W-1] ^ b_wide[ELEM_W] ^ op.sub;
                if (op.first) begin
                    r_acc <= '0;
                end
            end
            if (r_cnt >= CNT_W'(PP_FIRST) && r_cnt <= CNT_W'(PP_LAST)) begin
                r_pp    <= ELEM_W'(r_mag_a[dig[2:1]*DIG_W +: DIG_W])
                         * ELEM_W'(r_mag_b[dig[0]*DIG_W +: DIG_W]);
                r_pp_sh <= {1'b0, dig[2:1]} + {2'b00, dig[0]};
            end
            if (r_cnt >= CNT_W'(ACC_FIRST) && r_cnt <= CNT_W'(ACC_LAST)) begin
                r_acc <= r_neg ? r_acc - t_acc'(pp_sh) : r_acc + t_acc'(pp_sh);
            end
            if (r_cnt == CNT_W'(CNT_LAST)) begin
                case (op.dst)
                    DST_COF: r_cof             <= TMP_W'(r_acc);
                    DST_DET: r_det             <= r_acc;
                    DST_TMP: r_tmp[op.d_idx]   <= TMP_W'(r_acc);
                    DST_SIG: r_sig[op.d_idx]   <= r_acc;
                    default: ;
                endcase
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_det_part = r_det;
    assign o_sig      = r_sig;

endmodule

`default_nettype wire

// ===== rtl/p2c_div.sv =====
// Restoring divider: round(num * 2^24 / den), ties away from zero, saturated
// to the 48-bit field. One quotient bit a cycle. Depends on p2c_pkg.
`default_nettype none

module p2c_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  p2c_pkg::t_acc i_num,
    input  p2c_pkg::t_acc i_den,
    output logic          o_busy,
    output p2c_pkg::t_elem o_quo
);
    import p2c_pkg::*;

    localparam int                CNT_W   = $clog2(ELEM_W);
    localparam logic [ELEM_W:0]   NEG_LIM = (ELEM_W+1)'(1) << (ELEM_W - 1);
    localparam logic [ELEM_W:0]   POS_LIM = NEG_LIM - (ELEM_W+1)'(1);

    typedef enum logic [1:0] {DV_IDLE, DV_CMP, DV_ITER, DV_ROUND} t_state;

    t_state              r_state;
    logic [ACC_W-1:0]    r_rem;
    logic [ELEM_W-1:0]   r_lo;
    logic [ACC_W-1:0]    r_d;
    logic                r_neg;
    logic [ELEM_W-1:0]   r_q;
    logic [CNT_W-1:0]    r_cnt;
    t_elem               r_quo;

    logic [ACC_W-1:0]    num_abs;
    logic [ACC_W-1:0]    den_abs;
    logic [ACC_W-1:0]    trial;
    logic                ge;
    logic                up;
    logic [ELEM_W:0]     mag;

    always_comb begin
        num_abs = i_num[ACC_W-1] ? ACC_W'(-i_num) : ACC_W'(i_num);
        den_abs = i_den[ACC_W-1] ? ACC_W'(-i_den) : ACC_W'(i_den);
        trial   = {r_rem[ACC_W-2:0], r_lo[ELEM_W-1]};
        ge      = (trial >= r_d);
        up      = ({r_rem, 1'b0} >= {1'b0, r_d});
        mag     = {1'b0, r_q} + (ELEM_W+1)'(up);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
        end else begin
            unique case (r_state)
                DV_IDLE: begin
                    if (i_start) begin
                        // numerator shifted up by the fraction width
                        r_rem   <= num_abs >> (ELEM_W - FRAC_W);
                        r_lo    <= {num_abs[ELEM_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
                        r_d     <= den_abs;
                        r_neg   <= i_num[ACC_W-1] ^ i_den[ACC_W-1];
                        r_state <= DV_CMP;
                    end
                end
                DV_CMP: begin
                    // quotient of 2^48 or more saturates either way
                    if (r_rem >= r_d) begin
                        r_quo   <= r_neg ? SAT_MIN : SAT_MAX;
                        r_state <= DV_IDLE;
                    end else begin
                        r_cnt   <= CNT_W'(ELEM_W - 1);
                        r_state <= DV_ITER;
                    end
                end
                DV_ITER: begin
                    r_rem <= ge ? trial - r_d : trial;
                    r_lo  <= r_lo << 1;
                    r_q   <= {r_q[ELEM_W-2:0], ge};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= DV_ROUND;
                    end
                end
                DV_ROUND: begin
                    if (r_neg) begin
                        r_quo <= (mag > NEG_LIM) ? SAT_MIN : t_elem'(ELEM_W'(-mag));
                    end else begin
                        r_quo <= (mag > POS_LIM) ? SAT_MAX : t_elem'(mag[ELEM_W-1:0]);
                    end
                    r_state <= DV_IDLE;
                end
                default: r_state <= DV_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != DV_IDLE);
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// ===== rtl/p2c_chk.sv =====
// Port-level checks on the push-forward top level, bound to it below.
// Depends on p2c_pkg and the top level's ports.
`default_nettype none

module p2c_chk (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         out_valid,
    input wire         out_ready,
    input wire [1:0]   out_row,
    input wire [47:0]  cauchy_a,
    input wire [47:0]  cauchy_b,
    input wire [47:0]  cauchy_c,
    input wire         singular,
    input wire         last_row
);
    import p2c_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_row)
            && $stable(cauchy_a) && $stable(cauchy_b) && $stable(cauchy_c))
        else $error("result item changed while stalled");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (last_row == (out_row == ROW_LAST)))
        else $error("last_row does not match out_row");

    a_sing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && singular |-> cauchy_a == '0 && cauchy_b == '0 && cauchy_c == '0)
        else $error("singular item with nonzero values");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result item valid after reset");

endmodule

bind pk2_to_cauchy_stress_push_forward p2c_chk u_p2c_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_row   (o_out.out_row),
    .cauchy_a  (o_out.cauchy_a),
    .cauchy_b  (o_out.cauchy_b),
    .cauchy_c  (o_out.cauchy_c),
    .singular  (o_out.singular),
    .last_row  (o_out.last_row)
);

`default_nettype wire

// ===== sim/tb_pk2_to_cauchy_stress_push_forward.sv =====
// Self-checking testbench for the PK2 to Cauchy stress push-forward block.
// Drives row items over the input channel and checks every result row against
// a built-in wide-integer predictor. Depends on p2c_pkg, p2c_if and the RTL.

module tb_pk2_to_cauchy_stress_push_forward;
    import p2c_pkg::*;

    typedef logic signed [255:0] t_wide;

    typedef enum logic [1:0] {EXP_CALC, EXP_SING, EXP_IDENT} t_exp_kind;

    typedef struct {
        logic [1:0] row;
        t_elem      g [3];
        t_elem      s [3];
        t_exp_kind  kind;
    } t_row_item;

    typedef struct {
        logic [1:0] row;
        t_elem      v [3];
        logic       sing;
        logic       last;
    } t_sigma_row;

    localparam t_elem ONE = t_elem'(48'sd1 <<< FRAC_W);

    logic i_clk;
    logic i_rst_n;

    p2c_in_if  in_ch ();
    p2c_out_if out_ch ();

    pk2_to_cauchy_stress_push_forward i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_elem      grad_mem [CELLS];
    t_elem      stress_mem [CELLS];
    t_sigma_row sigma_q [$];
    t_row_item  directed [$];
    int         n_fail;
    int         n_sent;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // round(num * 2^24 / den), ties away from zero, saturated to 48 bits
    function automatic t_elem push_fwd_div(input t_wide num, input t_wide den);
        logic         neg;
        logic [255:0] n;
        logic [255:0] d;
        logic [255:0] q;
        logic [255:0] r;
        neg = num[255] ^ den[255];
        n   = num[255] ? -num : num;
        d   = den[255] ? -den : den;
        n   = n << FRAC_W;
        q   = n / d;
        r   = n % d;
        if ((r << 1) >= d) q = q + 1;
        if (neg) begin
            if (q > 256'h8000_0000_0000) return SAT_MIN;
            return t_elem'(-q[47:0]);
        end
        if (q > 256'h7FFF_FFFF_FFFF) return SAT_MAX;
        return t_elem'(q[47:0]);
    endfunction

    function automatic t_wide gw(input int r, input int c);
        return t_wide'(grad_mem[r*3 + c]);
    endfunction

    // stores the row and, on row 2, queues the three sigma rows
    function automatic void predict_sigma(input t_row_item it);
        t_wide      det;
        t_wide      acc;
        t_sigma_row res;
        if (it.row == 2'd3) return;
        for (int j = 0; j < 3; j++) begin
            grad_mem[it.row*3 + j]   = it.g[j];
            stress_mem[it.row*3 + j] = it.s[j];
        end
        if (it.row != ROW_LAST) return;
        det = gw(0,0)*gw(1,1)*gw(2,2) + gw(0,1)*gw(1,2)*gw(2,0)
            + gw(0,2)*gw(1,0)*gw(2,1) - gw(0,2)*gw(1,1)*gw(2,0)
            - gw(0,0)*gw(1,2)*gw(2,1) - gw(0,1)*gw(1,0)*gw(2,2);
        for (int i = 0; i < 3; i++) begin
            res.row  = 2'(i);
            res.sing = (det == 0);
            res.last = (i == 2);
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int a = 0; a < 3; a++)
                    for (int b = 0; b < 3; b++)
                        acc = acc + gw(i,a) * t_wide'(stress_mem[a*3 + b]) * gw(j,b);
                case (it.kind)
                    EXP_SING:  res.v[j] = '0;
                    EXP_IDENT: res.v[j] = stress_mem[i*3 + j];
                    default:   res.v[j] = res.sing ? t_elem'(0) : push_fwd_div(acc, det);
                endcase
            end
            if (it.kind == EXP_SING) res.sing = 1'b1;
            if (it.kind == EXP_IDENT) res.sing = 1'b0;
            sigma_q.push_back(res);
        end
    endfunction

    function automatic t_elem rnd_elem(input int mode);
        t_elem v;
        case (mode)
            0: v = t_elem'({$urandom, $urandom});
            1: v = t_elem'($signed(27'($urandom)));
            default: begin
                case ($urandom_range(0, 4))
                    0: v = SAT_MAX;
                    1: v = SAT_MIN;
                    2: v = ONE;
                    3: v = -ONE;
                    default: v = '0;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic t_row_item mk_row(input logic [1:0] row, input t_elem g0,
                                         input t_elem g1, input t_elem g2,
                                         input t_elem s0, input t_elem s1,
                                         input t_elem s2, input t_exp_kind k);
        t_row_item it;
        it.row  = row;
        it.g[0] = g0; it.g[1] = g1; it.g[2] = g2;
        it.s[0] = s0; it.s[1] = s1; it.s[2] = s2;
        it.kind = k;
        return it;
    endfunction

    function automatic t_row_item rnd_row(input logic [1:0] row, input int mode);
        t_row_item it;
        it.row  = row;
        it.kind = EXP_CALC;
        for (int j = 0; j < 3; j++) begin
            it.g[j] = rnd_elem(mode);
            it.s[j] = rnd_elem(mode);
        end
        return it;
    endfunction

    task automatic send_row(input t_row_item it);
        int gap;
        in_ch.valid     <= 1'b1;
        in_ch.row_index <= it.row;
        in_ch.grad_a    <= it.g[0];
        in_ch.grad_b    <= it.g[1];
        in_ch.grad_c    <= it.g[2];
        in_ch.stress_a  <= it.s[0];
        in_ch.stress_b  <= it.s[1];
        in_ch.stress_c  <= it.s[2];
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_sigma(it);
        n_sent++;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
              ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // result side back-pressure: runs of ready, short and occasional long stalls
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            if ($urandom_range(0, 3) != 0) begin
                out_ch.ready <= 1'b0;
                repeat (($urandom_range(0, 7) == 0) ? $urandom_range(10, 50) :
                        $urandom_range(1, 3)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_sigma_row e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (sigma_q.size() == 0) begin
                $display("%0t: unexpected result row %0d", $time, out_ch.out_row);
                n_fail++;
            end else begin
                e = sigma_q.pop_front();
                if (out_ch.out_row !== e.row) begin
                    $display("%0t: out_row exp %0d got %0d", $time, e.row, out_ch.out_row);
                    n_fail++;
                end
                if (out_ch.cauchy_a !== e.v[0]) begin
                    $display("%0t: cauchy_a exp %h got %h", $time, e.v[0], out_ch.cauchy_a);
                    n_fail++;
                end
                if (out_ch.cauchy_b !== e.v[1]) begin
                    $display("%0t: cauchy_b exp %h got %h", $time, e.v[1], out_ch.cauchy_b);
                    n_fail++;
                end
                if (out_ch.cauchy_c !== e.v[2]) begin
                    $display("%0t: cauchy_c exp %h got %h", $time, e.v[2], out_ch.cauchy_c);
                    n_fail++;
                end
                if (out_ch.singular !== e.sing) begin
                    $display("%0t: singular exp %b got %b", $time, e.sing, out_ch.singular);
                    n_fail++;
                end
                if (out_ch.last_row !== e.last) begin
                    $display("%0t: last_row exp %b got %b", $time, e.last, out_ch.last_row);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        int        mode;
        int        waited;
        t_row_item it;
        t_elem     tiny;
        n_fail = 0;
        n_sent = 0;
        tiny   = t_elem'(1);
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.row_index  = '0;
        in_ch.grad_a     = '0;
        in_ch.grad_b     = '0;
        in_ch.grad_c     = '0;
        in_ch.stress_a   = '0;
        in_ch.stress_b   = '0;
        in_ch.stress_c   = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ignored row index, then identity F (sigma equals S)
        directed.push_back(mk_row(2'd3, SAT_MIN, SAT_MAX, -1, -1, SAT_MIN, SAT_MAX, EXP_CALC));
        directed.push_back(mk_row(2'd0, ONE, 0, 0, 3 * ONE, -ONE, ONE / 2, EXP_CALC));
        directed.push_back(mk_row(2'd1, 0, ONE, 0, SAT_MAX, SAT_MIN, 0, EXP_CALC));
        directed.push_back(mk_row(2'd2, 0, 0, ONE, -5, 7, -ONE, EXP_IDENT));
        // zero row in F
        directed.push_back(mk_row(2'd0, 2 * ONE, ONE, 0, ONE, ONE, ONE, EXP_CALC));
        directed.push_back(mk_row(2'd1, ONE, 3 * ONE, ONE, ONE, 2 * ONE, ONE, EXP_CALC));
        directed.push_back(mk_row(2'd2, 0, 0, 0, ONE, ONE, 4 * ONE, EXP_SING));
        // F all at the top bound: rank one
        directed.push_back(mk_row(2'd0, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN, SAT_MIN, SAT_MIN, EXP_CALC));
        directed.push_back(mk_row(2'd1, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN, SAT_MIN, SAT_MIN, EXP_CALC));
        directed.push_back(mk_row(2'd2, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN, SAT_MIN, SAT_MIN, EXP_SING));
        // tiny det: quotients saturate both ways
        directed.push_back(mk_row(2'd0, tiny, 0, 0, ONE, -ONE, ONE, EXP_CALC));
        directed.push_back(mk_row(2'd1, 0, tiny, 0, -ONE, ONE, SAT_MAX, EXP_CALC));
        directed.push_back(mk_row(2'd2, 0, 0, -tiny, ONE, SAT_MIN, 1, EXP_CALC));
        // extreme diagonal F
        directed.push_back(mk_row(2'd0, SAT_MIN, 0, 0, SAT_MAX, SAT_MIN, 1, EXP_CALC));
        directed.push_back(mk_row(2'd1, 0, SAT_MAX, 0, -1, SAT_MAX, SAT_MIN, EXP_CALC));
        directed.push_back(mk_row(2'd2, 0, 0, SAT_MAX, SAT_MIN, 0, SAT_MAX, EXP_CALC));
        // stale rows reused, ignored row mid-set, rows out of order
        directed.push_back(mk_row(2'd2, ONE, -ONE, ONE, ONE, 0, -ONE, EXP_CALC));
        directed.push_back(mk_row(2'd1, -ONE, ONE / 4, 3, ONE, ONE, 0, EXP_CALC));
        directed.push_back(mk_row(2'd3, 0, 0, 0, 0, 0, 0, EXP_CALC));
        directed.push_back(mk_row(2'd0, ONE / 3, ONE, -ONE / 2, 2, -2, ONE, EXP_CALC));
        directed.push_back(mk_row(2'd2, ONE / 7, ONE * 5, -ONE, 1, ONE, -ONE, EXP_CALC));

        foreach (directed[k]) send_row(directed[k]);

        while (n_sent < 450) begin
            case ($urandom_range(0, 19))
                0, 1: begin
                    // noise: any row index on its own
                    send_row(rnd_row(2'($urandom_range(0, 3)), $urandom_range(0, 2)));
                end
                2: begin
                    // singular: row 2 of F repeats row 0
                    it = rnd_row(2'd0, 1);
                    send_row(it);
                    send_row(rnd_row(2'd1, 1));
                    it.row = 2'd2;
                    for (int j = 0; j < 3; j++) it.s[j] = rnd_elem(0);
                    send_row(it);
                end
                default: begin
                    mode = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(0, 2);
                    for (int r = 0; r < 3; r++) send_row(rnd_row(2'(r), mode));
                end
            endcase
        end
        in_ch.valid <= 1'b0;

        waited = 0;
        while (sigma_q.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (500) @(posedge i_clk);
        if (n_fail == 0 && sigma_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
